/* rtl/tgs_pkg.sv */
// ----------------------------------------------------------------------------
// tgs_pkg
// shared types and constants of the tripod gait sequencer
// ----------------------------------------------------------------------------
package tgs_pkg;

    localparam int LEG_COUNT_DEF = 6;

    // field widths
    localparam int CMD_W     = 3;
    localparam int ELAPSED_W = 20;
    localparam int PHASE_W   = 16;
    localparam int HALF_W    = 24;
    localparam int TMO_W     = 22;
    localparam int GROUP_W   = 6;
    localparam int DT_W      = 17;
    localparam int SINCE_W   = 32;
    localparam int IDX_W     = 3;
    localparam int CFG_DW    = 24;
    localparam int CFG_AW    = 2;
    localparam int OUT_DW    = 48;
    localparam int IN_DW     = 24;
    localparam int IN_UW     = 3;

    localparam logic [HALF_W-1:0]  HALF_CYCLE_RST = 24'd500000;
    localparam logic [GROUP_W-1:0] GROUP_B_RST    = 6'd42;
    localparam logic [DT_W-1:0]    DT_CLAMP       = 17'd100000;
    localparam logic [PHASE_W-1:0] HALF_Q16       = 16'h8000;
    localparam logic [SINCE_W-1:0] MS_US          = 32'd1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 3'd0,
        CMD_ENABLE  = 3'd1,
        CMD_DISABLE = 3'd2,
        CMD_BEAT    = 3'd3,
        CMD_STOP    = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WALK = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_HALF_CYCLE = 2'd0,
        CFG_TIMEOUT    = 2'd1,
        CFG_GROUP_B    = 2'd2
    } cfg_idx_t;

    // control from the sequencer to the leg bank
    typedef struct packed {
        logic init;
        logic freeze_stance;
        logic clear_edges;
        logic step;
        logic stopping;
    } leg_ctl_t;

    // status of the selected leg
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               flying;
        logic               lift;
        logic               land;
        logic               frozen;
    } leg_stat_t;

endpackage

/* rtl/tgs_div.sv */
// ----------------------------------------------------------------------------
// tgs_div
// bit-serial restoring divider for the phase increment, one quotient bit a cycle
// ----------------------------------------------------------------------------
module tgs_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tgs_pkg::DT_W-1:0]     dt,
    input  logic [tgs_pkg::HALF_W-1:0]   divisor,
    output logic                         done,
    output logic [tgs_pkg::PHASE_W-1:0]  quotient
);
    import tgs_pkg::*;

    localparam int REM_W = HALF_W + 1;
    localparam int CNT_W = $clog2(PHASE_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [PHASE_W-1:0]  q_reg, q_next;
    logic [REM_W-1:0]    rem_shl;
    logic                take;
    logic                sat;

    // quotient would reach one whole when dt is not below the divisor
    assign sat     = {{(HALF_W-DT_W){1'b0}}, dt} >= divisor;
    assign rem_shl = {rem_reg[REM_W-2:0], 1'b0};
    assign take    = rem_shl >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            if (sat)
            begin
                q_next    = '1;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = REM_W'(dt);
                q_next    = '0;
                cnt_next  = CNT_W'(PHASE_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = take ? (rem_shl - {1'b0, divisor}) : rem_shl;
            q_next   = {q_reg[PHASE_W-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

/* rtl/tgs_legs.sv */
// ----------------------------------------------------------------------------
// tgs_legs
// per-leg phase, flight and freeze state, stepped one leg a cycle
// ----------------------------------------------------------------------------
module tgs_legs #(
    parameter int LEG_COUNT = tgs_pkg::LEG_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tgs_pkg::leg_ctl_t             ctl,
    input  logic [$clog2(LEG_COUNT)-1:0]  sel,
    input  logic [tgs_pkg::PHASE_W-1:0]   inc,
    input  logic [tgs_pkg::GROUP_W-1:0]   group_b,
    output tgs_pkg::leg_stat_t            stat,
    output logic                          all_frozen
);
    import tgs_pkg::*;

    localparam int EXT_W = LEG_COUNT + GROUP_W;
    localparam logic [EXT_W-1:0] GB_RST_EXT = EXT_W'(GROUP_B_RST);

    logic [PHASE_W-1:0]   phase_reg [LEG_COUNT];
    logic [LEG_COUNT-1:0] wf_reg;
    logic [LEG_COUNT-1:0] frz_reg;
    logic [LEG_COUNT-1:0] lift_reg;
    logic [LEG_COUNT-1:0] land_reg;
    logic [EXT_W-1:0]     gb_ext;
    logic [PHASE_W-1:0]   phase_next;
    logic                 fl_next;

    // legs beyond the group mask always start at zero
    assign gb_ext     = EXT_W'(group_b);
    assign phase_next = phase_reg[sel] + inc;
    assign fl_next    = phase_next[PHASE_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEG_COUNT; i++)
            begin
                phase_reg[i] <= GB_RST_EXT[i] ? HALF_Q16 : '0;
            end
            wf_reg   <= '0;
            frz_reg  <= '0;
            lift_reg <= '0;
            land_reg <= '0;
        end
        else
        begin
            if (ctl.clear_edges)
            begin
                lift_reg <= '0;
                land_reg <= '0;
            end
            if (ctl.init)
            begin
                for (int i = 0; i < LEG_COUNT; i++)
                begin
                    phase_reg[i] <= gb_ext[i] ? HALF_Q16 : '0;
                end
                wf_reg  <= '0;
                frz_reg <= '0;
            end
            if (ctl.freeze_stance)
            begin
                frz_reg <= frz_reg | ~wf_reg;
            end
            if (ctl.step && !frz_reg[sel])
            begin
                phase_reg[sel] <= phase_next;
                lift_reg[sel]  <= fl_next & ~wf_reg[sel];
                land_reg[sel]  <= ~fl_next & wf_reg[sel];
                wf_reg[sel]    <= fl_next;
                if (!fl_next && wf_reg[sel] && ctl.stopping)
                begin
                    frz_reg[sel] <= 1'b1;
                end
            end
        end
    end

    assign stat.phase  = phase_reg[sel];
    assign stat.flying = wf_reg[sel];
    assign stat.lift   = lift_reg[sel];
    assign stat.land   = land_reg[sel];
    assign stat.frozen = frz_reg[sel];
    assign all_frozen  = &frz_reg;

endmodule

/* rtl/tripod_gait_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tripod_gait_sequencer_core
// tripod gait phase sequencer: mode control, watchdog, serial increment
// division, one leg stepped per cycle and one status item per leg out
// ----------------------------------------------------------------------------
//  channel   direction  handshake          contents
//  s_*       in         s_tvalid/s_tready  command and elapsed time
//  m_*       out        m_tvalid/m_tready  leg status, LEG_COUNT items per input
//  cfg_*     in         cfg_we             register writes, no read-back
//
//  a tick that moves the legs passes decode, the watchdog check, the 16-step
//  divider, stepping of each leg, a settle state and one report per leg; the
//  divider skips its steps when the increment saturates; a tick while idle
//  skips the divider and stepping, any other item goes from decode to reports
//  one item is in work at a time; output stalls hold the report phase
//  rst_n is asynchronous and active low and restores the register defaults
// ----------------------------------------------------------------------------
module tripod_gait_sequencer_core #(
    parameter int LEG_COUNT = tgs_pkg::LEG_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // slave side
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tgs_pkg::IN_DW-1:0]    s_tdata,   // elapsed_us[19:0], zero pad
    input  logic [tgs_pkg::IN_UW-1:0]    s_tuser,   // cmd[2:0]
    // master side
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tgs_pkg::OUT_DW-1:0]   m_tdata,   // leg_index[2:0], gait_mode[4:3],
                                                    // leg_phase[20:5],
                                                    // swing_progress[36:21],
                                                    // leg_flying[37], lift_off[38],
                                                    // touch_down[39], leg_frozen[40],
                                                    // watchdog_fired[41], zero pad
    output logic                         m_tlast,   // last_leg
    // configuration
    input  logic                         cfg_we,
    input  logic [tgs_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [tgs_pkg::CFG_DW-1:0]   cfg_data
);
    import tgs_pkg::*;

    localparam int LW = $clog2(LEG_COUNT);
    localparam logic [LW-1:0] LAST_LEG = LW'(LEG_COUNT - 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_WDOG   = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_LEGS   = 7'b0010000,
        ST_SETTLE = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    mode_t                 mode_reg, mode_next;

    // configuration
    logic [HALF_W-1:0]     half_cycle_reg;
    logic [GROUP_W-1:0]    group_b_reg;
    logic                  wd_en_reg;
    logic [SINCE_W-1:0]    wd_limit_reg;

    // item in work
    logic [CMD_W-1:0]      cmd_reg;
    logic [ELAPSED_W-1:0]  elapsed_reg;
    logic [SINCE_W-1:0]    since_reg, since_next;
    logic                  wd_reg, wd_next;
    logic [LW-1:0]         leg_cnt_reg, leg_cnt_next;

    // output register
    logic                  m_tvalid_reg;
    logic [OUT_DW-1:0]     m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  out_load;

    logic [SINCE_W:0]      since_sum;
    logic [DT_W-1:0]       dt;
    logic                  wd_fire;
    logic                  div_start;
    logic                  div_done;
    logic [PHASE_W-1:0]    inc;
    leg_ctl_t              ctl;
    leg_stat_t             stat;
    logic                  all_frozen;
    logic [PHASE_W-1:0]    swing;

    assign s_tready = (state_reg == ST_IDLE);

    // saturating time since the last enable or beat command or timeout write
    assign since_sum = {1'b0, since_reg} + (SINCE_W+1)'(elapsed_reg);

    // phase step is clamped to a tenth of a second
    assign dt = ({{(DT_W > ELAPSED_W ? 0 : ELAPSED_W-DT_W){1'b0}}, DT_CLAMP} <
                 ELAPSED_W'(elapsed_reg)) ? DT_CLAMP : DT_W'(elapsed_reg);

    // since/1000 > timeout is the same as since >= (timeout+1)*1000
    assign wd_fire = (mode_reg == MODE_WALK) && wd_en_reg && (since_reg >= wd_limit_reg);

    tgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dt       (dt),
        .divisor  (half_cycle_reg),
        .done     (div_done),
        .quotient (inc)
    );

    tgs_legs #(
        .LEG_COUNT (LEG_COUNT)
    ) u_legs (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sel        (leg_cnt_reg),
        .inc        (inc),
        .group_b    (group_b_reg),
        .stat       (stat),
        .all_frozen (all_frozen)
    );

    assign out_load = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        since_next   = since_reg;
        wd_next      = wd_reg;
        leg_cnt_next = leg_cnt_reg;
        div_start    = 1'b0;
        ctl          = '0;
        ctl.stopping = (mode_reg == MODE_STOP);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                wd_next         = 1'b0;
                ctl.clear_edges = 1'b1;
                leg_cnt_next    = '0;
                state_next      = ST_EMIT;
                case (cmd_reg)
                    CMD_TICK:
                    begin
                        since_next = since_sum[SINCE_W] ? '1 : since_sum[SINCE_W-1:0];
                        if (elapsed_reg != '0)
                        begin
                            state_next = ST_WDOG;
                        end
                    end
                    CMD_ENABLE:
                    begin
                        since_next = '0;
                        if (mode_reg == MODE_IDLE)
                        begin
                            mode_next = MODE_WALK;
                            ctl.init  = 1'b1;
                        end
                    end
                    CMD_DISABLE:
                    begin
                        if (mode_reg == MODE_WALK)
                        begin
                            mode_next         = MODE_STOP;
                            ctl.freeze_stance = 1'b1;
                        end
                    end
                    CMD_BEAT:
                    begin
                        since_next = '0;
                    end
                    CMD_STOP:
                    begin
                        mode_next = MODE_IDLE;
                        ctl.init  = 1'b1;
                    end
                    default:
                    begin
                        // unknown command, status only
                    end
                endcase
            end
            ST_WDOG:
            begin
                if (wd_fire)
                begin
                    mode_next         = MODE_STOP;
                    ctl.freeze_stance = 1'b1;
                    wd_next           = 1'b1;
                    div_start         = 1'b1;
                    state_next        = ST_DIV;
                end
                else if (mode_reg != MODE_IDLE)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    leg_cnt_next = '0;
                    state_next   = ST_LEGS;
                end
            end
            ST_LEGS:
            begin
                ctl.step = 1'b1;
                if (leg_cnt_reg == LAST_LEG)
                begin
                    leg_cnt_next = '0;
                    state_next   = ST_SETTLE;
                end
                else
                begin
                    leg_cnt_next = leg_cnt_reg + LW'(1);
                end
            end
            ST_SETTLE:
            begin
                // stopping ends once every leg stands frozen
                if (mode_reg == MODE_STOP && all_frozen)
                begin
                    mode_next = MODE_IDLE;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    if (leg_cnt_reg == LAST_LEG)
                    begin
                        leg_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        leg_cnt_next = leg_cnt_reg + LW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a timeout write restarts the watchdog window
        if (cfg_we && cfg_addr == CFG_TIMEOUT)
        begin
            since_next = '0;
        end
    end

    // swing progress is (phase - half) * 2 while in flight
    assign swing = (stat.flying && stat.phase[PHASE_W-1]) ?
                   {stat.phase[PHASE_W-2:0], 1'b0} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_IDLE;
            since_reg      <= '0;
            wd_reg         <= 1'b0;
            leg_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            half_cycle_reg <= HALF_CYCLE_RST;
            group_b_reg    <= GROUP_B_RST;
            wd_en_reg      <= 1'b0;
            wd_limit_reg   <= MS_US;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            since_reg   <= since_next;
            wd_reg      <= wd_next;
            leg_cnt_reg <= leg_cnt_next;

            if (state_reg == ST_EMIT && out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_HALF_CYCLE:
                    begin
                        half_cycle_reg <= cfg_data[HALF_W-1:0];
                    end
                    CFG_TIMEOUT:
                    begin
                        wd_en_reg    <= (cfg_data[TMO_W-1:0] != '0);
                        wd_limit_reg <= SINCE_W'((SINCE_W'(cfg_data[TMO_W-1:0]) +
                                                  SINCE_W'(1)) * MS_US);
                    end
                    CFG_GROUP_B:
                    begin
                        group_b_reg <= cfg_data[GROUP_W-1:0];
                    end
                    default:
                    begin
                        // no register at this index
                    end
                endcase
            end
        end
    end

    // item capture and output payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg     <= s_tuser[CMD_W-1:0];
            elapsed_reg <= s_tdata[ELAPSED_W-1:0];
        end
        if (state_reg == ST_EMIT && out_load)
        begin
            m_tdata_reg <= {{(OUT_DW-42){1'b0}},
                            wd_reg,
                            stat.frozen,
                            stat.land,
                            stat.lift,
                            stat.flying,
                            swing,
                            stat.phase,
                            mode_reg,
                            IDX_W'(leg_cnt_reg)};
            m_tlast_reg <= (leg_cnt_reg == LAST_LEG);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
